// ===== hw/rtl/mchw_pkg.sv =====
// Package for the multi-channel heartbeat watchdog.
// Holds command codes, queue entry type, back-end states and fixed field widths.
// No dependencies.
`default_nettype none

package mchw_pkg;

	// Fixed field widths
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned STAGE_W   = 3;
	localparam int unsigned TMO_W     = 16;
	localparam int unsigned ELAPSED_W = 17;
	localparam int unsigned FOUND_W   = 4;

	// Saturation value of an elapsed count
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

	// Most expiry results that one scan may report
	localparam logic [FOUND_W-1:0] MAX_OUT = 4'd8;

	// Reset value of the check interval register
	localparam logic [TMO_W-1:0] CHECK_INTERVAL_RESET = 16'd100;

	// Depth of the command queue between front and back
	localparam int unsigned Q_DEPTH = 2;

	// Command codes as they arrive on the command channel
	typedef enum logic [CMD_W-1:0] {
		OP_REG   = 2'd0,
		OP_HB    = 2'd1,
		OP_UNREG = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// One queued command
	typedef struct packed {
		op_t                op;
		logic [STAGE_W-1:0] stage;
		logic [TMO_W-1:0]   timeout;
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic {
		BK_EXEC = 1'b0,
		BK_SCAN = 1'b1
	} bk_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mchw_ifs.sv =====
// Channel interfaces of the heartbeat watchdog: command channel and result channel.
// Depends on mchw_pkg for field widths.
`default_nettype none

interface mchw_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [mchw_pkg::CMD_W-1:0]    command;
	logic [mchw_pkg::STAGE_W-1:0]  stage;
	logic [mchw_pkg::TMO_W-1:0]    timeout;

	modport source (output valid, output command, output stage, output timeout, input ready);
	modport sink   (input valid, input command, input stage, input timeout, output ready);
endinterface

interface mchw_res_if;
	logic                          valid;
	logic                          ready;
	logic [mchw_pkg::STAGE_W-1:0]  expired_stage;
	logic                          last;

	modport source (output valid, output expired_stage, output last, input ready);
	modport sink   (input valid, input expired_stage, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mchw_front.sv =====
// Front end of the heartbeat watchdog: accepts commands, drops out-of-range slots
// and queues the rest for the back end. Depends on mchw_pkg and mchw_ifs.
`default_nettype none

module mchw_front #(
	parameter int unsigned NUM_STAGES = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	mchw_cmd_if.sink            cmd,
	output mchw_pkg::cmd_t      q_cmd,
	output logic                q_valid,
	input  wire logic           q_pop
);

	localparam int unsigned CNT_W = $clog2(mchw_pkg::Q_DEPTH + 1);

	mchw_pkg::cmd_t      fifo_q [mchw_pkg::Q_DEPTH];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                accept;
	logic                keep;
	logic                push;
	mchw_pkg::cmd_t      entry;

	// Classify: ticks always pass, slot commands only for slots that exist
	always_comb begin
		entry.op      = mchw_pkg::op_t'(cmd.command);
		entry.stage   = cmd.stage;
		entry.timeout = cmd.timeout;
		keep = (entry.op == mchw_pkg::OP_TICK) || (32'(cmd.stage) < NUM_STAGES);
	end

	assign cmd.ready = (count_q != CNT_W'(mchw_pkg::Q_DEPTH));
	assign accept    = cmd.valid && cmd.ready;
	assign push      = accept && keep;

	assign q_valid = (count_q != '0);
	assign q_cmd   = fifo_q[rd_ptr_q];

	// Store queued commands
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(mchw_pkg::Q_DEPTH))
		else $error("command queue over-filled");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty command queue");

endmodule

`default_nettype wire

// ===== hw/rtl/mchw_back.sv =====
// Back end of the heartbeat watchdog: slot state, tick counting, timeout scan and
// the result register. Depends on mchw_pkg and mchw_ifs.
`default_nettype none

module mchw_back #(
	parameter int unsigned NUM_STAGES = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mchw_pkg::TMO_W-1:0]    cfg_wdata,
	input  mchw_pkg::cmd_t                     q_cmd,
	input  wire logic                          q_valid,
	output logic                               q_pop,
	mchw_res_if.source                         res
);

	localparam int unsigned IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_STAGES + 1);

	// Slot state
	logic [NUM_STAGES-1:0]                 active_q;
	logic [mchw_pkg::TMO_W-1:0]            tmo_q     [NUM_STAGES];
	logic [mchw_pkg::ELAPSED_W-1:0]        elapsed_q [NUM_STAGES];
	logic [NUM_STAGES-1:0]                 over;

	// Tick and scan control
	logic [mchw_pkg::TMO_W-1:0]            check_interval_q;
	logic [mchw_pkg::TMO_W-1:0]            interval_q;
	mchw_pkg::bk_state_t                   state_q, state_d;
	logic [CNT_W-1:0]                      scan_idx_q;
	logic [mchw_pkg::FOUND_W-1:0]          found_q;
	logic                                  pend_v_q;
	logic [mchw_pkg::STAGE_W-1:0]          pend_stage_q;

	// Result register
	logic                                  res_valid_q;
	logic [mchw_pkg::STAGE_W-1:0]          res_stage_q;
	logic                                  res_last_q;

	logic [IDX_W-1:0]                      cmd_idx;
	logic [IDX_W-1:0]                      scan_slot;
	logic [mchw_pkg::TMO_W:0]              interval_next;
	logic [mchw_pkg::TMO_W:0]              limit;
	logic                                  scan_now;
	logic                                  tick_go;
	logic                                  scan_end;
	logic                                  cur_over;
	logic                                  out_free;
	logic                                  hit;
	logic                                  adv;
	logic                                  emit;
	logic                                  emit_last;
	logic                                  finish;

	assign cmd_idx   = IDX_W'(q_cmd.stage);
	assign scan_slot = scan_idx_q[IDX_W-1:0];

	// Flag every active slot whose elapsed count is past its timeout
	always_comb begin
		for (int i = 0; i < NUM_STAGES; i++) begin
			over[i] = active_q[i] && (elapsed_q[i] > {1'b0, tmo_q[i]});
		end
	end

	// Interval compare; a zero interval behaves as one
	always_comb begin
		interval_next = {1'b0, interval_q} + 1'b1;
		limit         = (check_interval_q == '0) ? 17'd1 : {1'b0, check_interval_q};
		scan_now      = (interval_next >= limit);
	end

	assign scan_end = (scan_idx_q == CNT_W'(NUM_STAGES)) || (found_q == mchw_pkg::MAX_OUT);
	assign cur_over = over[scan_slot];
	assign out_free = !res_valid_q || res.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mchw_pkg::BK_EXEC: begin
				if (q_valid && (q_cmd.op == mchw_pkg::OP_TICK) && scan_now) begin
					state_d = mchw_pkg::BK_SCAN;
				end
			end
			mchw_pkg::BK_SCAN: begin
				if (scan_end && (!pend_v_q || out_free)) begin
					state_d = mchw_pkg::BK_EXEC;
				end
			end
			default: state_d = mchw_pkg::BK_EXEC;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		q_pop     = 1'b0;
		hit       = 1'b0;
		adv       = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			mchw_pkg::BK_EXEC: begin
				q_pop = q_valid;
			end
			mchw_pkg::BK_SCAN: begin
				if (scan_end) begin
					if (!pend_v_q) begin
						finish = 1'b1;
					end else if (out_free) begin
						emit      = 1'b1;
						emit_last = 1'b1;
						finish    = 1'b1;
					end
				end else if (cur_over) begin
					if (!pend_v_q || out_free) begin
						hit  = 1'b1;
						adv  = 1'b1;
						emit = pend_v_q;
					end
				end else begin
					adv = 1'b1;
				end
			end
			default: q_pop = 1'b0;
		endcase
	end

	assign tick_go = q_pop && (q_cmd.op == mchw_pkg::OP_TICK);

	// Hold state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= mchw_pkg::BK_EXEC;
			check_interval_q <= mchw_pkg::CHECK_INTERVAL_RESET;
			interval_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				check_interval_q <= cfg_wdata;
			end
			if (tick_go) begin
				interval_q <= scan_now ? '0 : interval_next[mchw_pkg::TMO_W-1:0];
			end
		end
	end

	// Update active marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (q_pop) begin
			if (q_cmd.op == mchw_pkg::OP_REG) begin
				active_q[cmd_idx] <= 1'b1;
			end else if (q_cmd.op == mchw_pkg::OP_UNREG) begin
				active_q[cmd_idx] <= 1'b0;
			end
		end
	end

	// Store timeouts on register
	always_ff @(posedge clk) begin
		if (q_pop && (q_cmd.op == mchw_pkg::OP_REG)) begin
			tmo_q[cmd_idx] <= q_cmd.timeout;
		end
	end

	// Advance, clear or saturate each elapsed count
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_STAGES; i++) begin
			if (tick_go) begin
				if (active_q[i] && (elapsed_q[i] != mchw_pkg::ELAPSED_MAX)) begin
					elapsed_q[i] <= elapsed_q[i] + 1'b1;
				end
			end else if (q_pop && (cmd_idx == IDX_W'(i))) begin
				if ((q_cmd.op == mchw_pkg::OP_REG) ||
				    ((q_cmd.op == mchw_pkg::OP_HB) && active_q[i])) begin
					elapsed_q[i] <= '0;
				end
			end else if (hit && (scan_slot == IDX_W'(i))) begin
				elapsed_q[i] <= '0;
			end
		end
	end

	// Walk the slots, holding one found expiry until the next decides its last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			found_q    <= '0;
			pend_v_q   <= 1'b0;
		end else begin
			if (tick_go && scan_now) begin
				scan_idx_q <= '0;
				found_q    <= '0;
				pend_v_q   <= 1'b0;
			end else begin
				if (adv) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (hit) begin
					found_q  <= found_q + 1'b1;
					pend_v_q <= 1'b1;
				end else if (finish) begin
					pend_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			pend_stage_q <= mchw_pkg::STAGE_W'(scan_idx_q);
		end
	end

	// Result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_stage_q <= pend_stage_q;
			res_last_q  <= emit_last;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.expired_stage = res_stage_q;
	assign res.last          = res_last_q;

	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= mchw_pkg::MAX_OUT)
		else $error("scan reported more than the result limit");

	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mchw_pkg::BK_EXEC) |-> !pend_v_q)
		else $error("pending expiry left behind after scan");

	a_scan_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_idx_q <= CNT_W'(NUM_STAGES))
		else $error("scan index ran past the last slot");

endmodule

`default_nettype wire

// ===== hw/rtl/multi_channel_heartbeat_watchdog.sv =====
// Top level of the multi-channel heartbeat watchdog.
// Depends on mchw_pkg, mchw_ifs, mchw_front and mchw_back.
//
// Watches NUM_STAGES slots. Commands (register, heartbeat, unregister, tick) enter through
// a two-entry queue; the back end executes each command as it pops it, and it pops only
// while it is not scanning. Every check_interval ticks a scan runs: the back end compares
// one slot per cycle unless a stalled result channel holds it, since one found expiry is
// held until the next one (or the end of the scan) fixes its last flag. Each expired slot
// produces one result and its count is cleared; at most eight results per scan.
// check_interval resets to 100 and a value of 0 scans on every tick; write it only while
// the block is idle. No clearing pass runs after reset.
`default_nettype none

module multi_channel_heartbeat_watchdog #(
	parameter int unsigned NUM_STAGES = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mchw_cmd_if.sink                           cmd,
	mchw_res_if.source                         res,
	input  wire logic                          cfg_we,
	input  wire logic [mchw_pkg::TMO_W-1:0]    cfg_wdata
);

	mchw_pkg::cmd_t q_cmd;
	logic           q_valid;
	logic           q_pop;

	// Accept, classify and queue commands
	mchw_front #(
		.NUM_STAGES (NUM_STAGES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_cmd   (q_cmd),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	// Execute commands, scan and deliver results
	mchw_back #(
		.NUM_STAGES (NUM_STAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_cmd     (q_cmd),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.res       (res)
	);

endmodule

`default_nettype wire
